// ----- sv/ssme_pkg.sv -----
// Package for the sorted set merge engine: command and status codes,
// the result word type and shared constants. No dependencies.
package ssme_pkg;

   localparam int DEF_SET_CAPACITY = 16;
   localparam int MAX_RESULTS      = 32;
   localparam int RES_CNT_W        = $clog2(MAX_RESULTS + 1);

   typedef logic [2:0]         kind_type;
   typedef logic [2:0]         status_type;
   typedef logic signed [31:0] elem_type;

   // command codes
   localparam kind_type KIND_INS_A = 3'd0;
   localparam kind_type KIND_INS_B = 3'd1;
   localparam kind_type KIND_CLEAR = 3'd2;
   localparam kind_type KIND_UNION = 3'd3;
   localparam kind_type KIND_DIFF  = 3'd4;
   localparam kind_type KIND_ISECT = 3'd5;

   // result status codes
   localparam status_type ST_ELEMENT   = 3'd0;
   localparam status_type ST_INSERTED  = 3'd1;
   localparam status_type ST_DUPLICATE = 3'd2;
   localparam status_type ST_FULL      = 3'd3;
   localparam status_type ST_EMPTY     = 3'd4;

   typedef struct packed {
      elem_type   element;
      status_type status;
      logic       last;
   } rsp_word_type;

endpackage

// ----- sv/ssme_if.sv -----
// Valid/ready channel interfaces for command and result words.
// Depends on ssme_pkg.
interface ssme_req_if;
   import ssme_pkg::*;
   logic     valid;
   logic     ready;
   kind_type kind;
   elem_type value;
   modport source (output valid, output kind, output value, input ready);
   modport sink (input valid, input kind, input value, output ready);
endinterface

interface ssme_rsp_if;
   import ssme_pkg::*;
   logic       valid;
   logic       ready;
   elem_type   element;
   status_type status;
   logic       last;
   modport source (output valid, output element, output status, output last, input ready);
   modport sink (input valid, input element, input status, input last, output ready);
endinterface

// ----- sv/ssme_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ssme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/ssme_ctrl.sv -----
// Sequencer for sorted insert, clear and merge walks over the two set RAMs.
// Depends on ssme_pkg; drives the RAM ports and the result register.
module ssme_ctrl #(
   parameter int SET_CAPACITY = ssme_pkg::DEF_SET_CAPACITY,
   localparam int IDX_W = $clog2(SET_CAPACITY),
   localparam int CNT_W = $clog2(SET_CAPACITY + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  ssme_pkg::kind_type     req_kind,
   input  ssme_pkg::elem_type     req_value,
   output logic                   req_ready,
   input  logic                   out_free,
   output logic                   push_valid,
   output ssme_pkg::rsp_word_type push_word,
   output logic                   a_wr_en,
   output logic                   b_wr_en,
   output logic [IDX_W-1:0]       wr_addr,
   output logic [31:0]            wr_data,
   output logic [IDX_W-1:0]       a_rd_addr,
   output logic [IDX_W-1:0]       b_rd_addr,
   input  logic [31:0]            a_rd_data,
   input  logic [31:0]            b_rd_data
);
   import ssme_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_SHIFT_RD, S_SHIFT_WR, S_PLACE,
      S_REPORT, S_MRG_RD, S_MRG_CMP, S_MRG_END
   } state_type;

   localparam logic [CNT_W-1:0] CAP     = CNT_W'(SET_CAPACITY);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   state_type              state_ff, state_in;
   logic                   sel_b_ff, sel_b_in;
   kind_type               kind_ff, kind_in;
   elem_type               value_ff, value_in;
   status_type             status_ff, status_in;
   logic [CNT_W-1:0]       count_a_ff, count_a_in;
   logic [CNT_W-1:0]       count_b_ff, count_b_in;
   logic [CNT_W-1:0]       pos_ff, pos_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       ia_ff, ia_in;
   logic [CNT_W-1:0]       ib_ff, ib_in;
   logic [RES_CNT_W-1:0]   res_cnt_ff, res_cnt_in;
   logic                   pend_valid_ff, pend_valid_in;
   elem_type               pend_ff, pend_in;

   logic [CNT_W-1:0] tcnt;
   logic [CNT_W-1:0] pos_nx;
   logic [31:0]      t_rdata;
   logic             merging;
   logic             a_ok, b_ok, take_a, take_b, emit_now;
   elem_type         emit_val;
   logic [IDX_W-1:0] ins_addr;

   assign tcnt    = sel_b_ff ? count_b_ff : count_a_ff;
   assign t_rdata = sel_b_ff ? b_rd_data : a_rd_data;
   assign pos_nx  = pos_ff + CNT_ONE;
   assign merging = (state_ff == S_MRG_RD) || (state_ff == S_MRG_CMP) ||
                    (state_ff == S_MRG_END);

   assign ins_addr  = ((state_ff == S_SHIFT_RD) || (state_ff == S_SHIFT_WR)) ?
                      idx_ff : pos_ff[IDX_W-1:0];
   assign a_rd_addr = merging ? ia_ff[IDX_W-1:0] : ins_addr;
   assign b_rd_addr = merging ? ib_ff[IDX_W-1:0] : ins_addr;

   assign wr_addr = (state_ff == S_SHIFT_WR) ? idx_ff + IDX_W'(1) : pos_ff[IDX_W-1:0];
   assign wr_data = (state_ff == S_SHIFT_WR) ? t_rdata : value_ff;
   assign a_wr_en = !sel_b_ff && ((state_ff == S_SHIFT_WR) || (state_ff == S_PLACE));
   assign b_wr_en = sel_b_ff && ((state_ff == S_SHIFT_WR) || (state_ff == S_PLACE));

   assign req_ready = (state_ff == S_IDLE);

   // merge step decision
   always_comb begin
      a_ok   = ia_ff < count_a_ff;
      b_ok   = ib_ff < count_b_ff;
      take_a = a_ok && (!b_ok || ($signed(a_rd_data) <= $signed(b_rd_data)));
      take_b = b_ok && (!a_ok || ($signed(b_rd_data) <= $signed(a_rd_data)));
      emit_val = $signed(a_rd_data);
      if (take_a && take_b) begin
         emit_now = (kind_ff == KIND_UNION) || (kind_ff == KIND_ISECT);
      end else if (take_a) begin
         emit_now = (kind_ff == KIND_UNION) || (kind_ff == KIND_DIFF);
      end else begin
         emit_now = (kind_ff == KIND_UNION);
         emit_val = $signed(b_rd_data);
      end
   end

   always_comb begin
      state_in      = state_ff;
      sel_b_in      = sel_b_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      count_a_in    = count_a_ff;
      count_b_in    = count_b_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      ia_in         = ia_ff;
      ib_in         = ib_ff;
      res_cnt_in    = res_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      push_valid    = 1'b0;
      push_word     = '{element: '0, status: ST_ELEMENT, last: 1'b0};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               value_in = req_value;
               case (req_kind)
                  KIND_INS_A, KIND_INS_B: begin
                     sel_b_in = (req_kind == KIND_INS_B);
                     pos_in   = '0;
                     if (((req_kind == KIND_INS_B) ? count_b_ff : count_a_ff) == '0) begin
                        state_in = S_PLACE;
                     end else begin
                        state_in = S_SRCH_RD;
                     end
                  end
                  KIND_CLEAR: begin
                     count_a_in = '0;
                     count_b_in = '0;
                     status_in  = ST_EMPTY;
                     state_in   = S_REPORT;
                  end
                  KIND_UNION, KIND_DIFF, KIND_ISECT: begin
                     ia_in         = '0;
                     ib_in         = '0;
                     res_cnt_in    = '0;
                     pend_valid_in = 1'b0;
                     state_in      = S_MRG_RD;
                  end
                  default: begin
                     // unused codes: drop the word
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SRCH_RD: begin
            state_in = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if ($signed(t_rdata) < value_ff) begin
               pos_in = pos_nx;
               if (pos_nx == tcnt) begin
                  if (tcnt == CAP) begin
                     status_in = ST_FULL;
                     state_in  = S_REPORT;
                  end else begin
                     state_in = S_PLACE;
                  end
               end else begin
                  state_in = S_SRCH_RD;
               end
            end else if ($signed(t_rdata) == value_ff) begin
               status_in = ST_DUPLICATE;
               state_in  = S_REPORT;
            end else if (tcnt == CAP) begin
               status_in = ST_FULL;
               state_in  = S_REPORT;
            end else begin
               idx_in   = IDX_W'(tcnt - CNT_ONE);
               state_in = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            // move one entry up, walking down to the insert position
            if (idx_ff == pos_ff[IDX_W-1:0]) begin
               state_in = S_PLACE;
            end else begin
               idx_in   = idx_ff - IDX_W'(1);
               state_in = S_SHIFT_RD;
            end
         end
         S_PLACE: begin
            if (sel_b_ff) begin
               count_b_in = count_b_ff + CNT_ONE;
            end else begin
               count_a_in = count_a_ff + CNT_ONE;
            end
            status_in = ST_INSERTED;
            state_in  = S_REPORT;
         end
         S_REPORT: begin
            if (out_free) begin
               push_valid = 1'b1;
               push_word  = '{element: '0, status: status_ff, last: 1'b1};
               state_in   = S_IDLE;
            end
         end
         S_MRG_RD: begin
            if ((!(ia_ff < count_a_ff) && !(ib_ff < count_b_ff)) ||
                (res_cnt_ff == RES_CNT_W'(MAX_RESULTS))) begin
               state_in = S_MRG_END;
            end else begin
               state_in = S_MRG_CMP;
            end
         end
         S_MRG_CMP: begin
            // hold while the previous element cannot leave
            if (!(emit_now && pend_valid_ff && !out_free)) begin
               if (emit_now) begin
                  if (pend_valid_ff) begin
                     push_valid = 1'b1;
                     push_word  = '{element: pend_ff, status: ST_ELEMENT, last: 1'b0};
                  end
                  pend_in       = emit_val;
                  pend_valid_in = 1'b1;
                  res_cnt_in    = res_cnt_ff + RES_CNT_W'(1);
               end
               ia_in    = ia_ff + {{(CNT_W-1){1'b0}}, take_a};
               ib_in    = ib_ff + {{(CNT_W-1){1'b0}}, take_b};
               state_in = S_MRG_RD;
            end
         end
         S_MRG_END: begin
            if (out_free) begin
               push_valid = 1'b1;
               if (pend_valid_ff) begin
                  push_word = '{element: pend_ff, status: ST_ELEMENT, last: 1'b1};
               end else begin
                  push_word = '{element: '0, status: ST_EMPTY, last: 1'b1};
               end
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_a_ff    <= '0;
         count_b_ff    <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_a_ff    <= count_a_in;
         count_b_ff    <= count_b_in;
         pend_valid_ff <= pend_valid_in;
      end
      sel_b_ff   <= sel_b_in;
      kind_ff    <= kind_in;
      value_ff   <= value_in;
      status_ff  <= status_in;
      pos_ff     <= pos_in;
      idx_ff     <= idx_in;
      ia_ff      <= ia_in;
      ib_ff      <= ib_in;
      res_cnt_ff <= res_cnt_in;
      pend_ff    <= pend_in;
   end

endmodule

// ----- sv/sorted_set_merge_engine_top.sv -----
// Sorted set merge engine: sets A and B in two RAMs with registered reads.
// Insert scans the target set for the position, shifts larger entries up
// and places the value; clear empties both sets; merge walks both stores
// a step at a time. One command in flight; the single RAM read port
// per set sets the step time. The result register lets the sequencer finish
// while the last word waits. Reset empties both sets; RAM contents are kept.
module sorted_set_merge_engine_top #(
   parameter int SET_CAPACITY = ssme_pkg::DEF_SET_CAPACITY
) (
   input logic         clock,
   input logic         reset,
   ssme_req_if.sink    req_ch,
   ssme_rsp_if.source  rsp_ch
);
   import ssme_pkg::*;

   localparam int IDX_W = $clog2(SET_CAPACITY);

   logic             push_valid;
   rsp_word_type     push_word;
   logic             out_free;
   logic             ready;
   logic             a_wr_en, b_wr_en;
   logic [IDX_W-1:0] wr_addr, a_rd_addr, b_rd_addr;
   logic [31:0]      wr_data, a_rd_data, b_rd_data;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   ssme_ctrl #(.SET_CAPACITY(SET_CAPACITY)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_kind   (req_ch.kind),
      .req_value  (req_ch.value),
      .req_ready  (ready),
      .out_free   (out_free),
      .push_valid (push_valid),
      .push_word  (push_word),
      .a_wr_en    (a_wr_en),
      .b_wr_en    (b_wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .a_rd_addr  (a_rd_addr),
      .b_rd_addr  (b_rd_addr),
      .a_rd_data  (a_rd_data),
      .b_rd_data  (b_rd_data)
   );

   ssme_ram #(.WIDTH(32), .DEPTH(SET_CAPACITY)) u_ram_a (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   ssme_ram #(.WIDTH(32), .DEPTH(SET_CAPACITY)) u_ram_b (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   assign req_ch.ready = ready;

   // result register: take a new word when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (push_valid) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = push_word;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.element = rsp_word_ff.element;
   assign rsp_ch.status  = rsp_word_ff.status;
   assign rsp_ch.last    = rsp_word_ff.last;

endmodule
